// File: sv/vaar_pkg.sv
// shared widths, types and the arctangent table of the axis-angle rotator
package vaar_pkg;

  localparam int VEC_W        = 32;              // q16.16 vector component
  localparam int AXIS_W       = 16;              // q2.14 axis component
  localparam int ANG_W        = 16;              // binary angle
  localparam int PHASE_W      = 32;              // cordic phase, one turn = 2^32
  localparam int TRIG_W       = 34;              // q2.30 with headroom
  localparam int ONE_SHIFT    = 30;              // fraction bits of sin and cos
  localparam int AXIS_FRAC    = 14;              // fraction bits of the axis
  localparam int GUARD        = 16;              // extra bits below a q16.16 lsb
  localparam int KV_W         = VEC_W + AXIS_W;  // axis times vector product
  localparam int MAG_W        = 52;              // wide term magnitudes
  localparam int HALF_W       = 26;              // split point of wide operands
  localparam int PROD_W       = 88;              // recombined wide product
  localparam int TERM_W       = 56;              // signed term on the guard grid
  localparam int ATAN_ENTRIES = 24;
  localparam int TRIG_ITERATIONS_DEF = 16;

  typedef logic signed [TRIG_W-1:0] trig_t;

  // trig results aligned to the vector lanes
  typedef struct packed {
    trig_t                 c;
    trig_t                 s;
    logic signed [TRIG_W:0] omc;   // one minus cos
  } trig_res_t;

  // per-lane vector data
  typedef struct packed {
    logic signed [VEC_W-1:0]  v;
    logic signed [AXIS_W-1:0] k;
    logic signed [MAG_W-1:0]  dotw;  // k.v on the guard grid
    logic signed [MAG_W-1:0]  cr;    // (v x k) component on the guard grid
  } vec_res_t;

  // arctangent of 2^-i in units of 2^-32 turn
  function automatic trig_t atan_turn(input int unsigned i);
    case (i)
      0:  return TRIG_W'(536870912);
      1:  return TRIG_W'(316933406);
      2:  return TRIG_W'(167458907);
      3:  return TRIG_W'(85004756);
      4:  return TRIG_W'(42667331);
      5:  return TRIG_W'(21354465);
      6:  return TRIG_W'(10679838);
      7:  return TRIG_W'(5340245);
      8:  return TRIG_W'(2670163);
      9:  return TRIG_W'(1335087);
      10: return TRIG_W'(667544);
      11: return TRIG_W'(333772);
      12: return TRIG_W'(166886);
      13: return TRIG_W'(83443);
      14: return TRIG_W'(41722);
      15: return TRIG_W'(20861);
      16: return TRIG_W'(10430);
      17: return TRIG_W'(5215);
      18: return TRIG_W'(2608);
      19: return TRIG_W'(1304);
      20: return TRIG_W'(652);
      21: return TRIG_W'(326);
      22: return TRIG_W'(163);
      23: return TRIG_W'(81);
      default: return '0;
    endcase
  endfunction

endpackage

// File: sv/vaar_cordic.sv
// pipelined rotation-mode cordic giving cos, sin and one minus cos in q2.30
module vaar_cordic import vaar_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [ANG_W-1:0] angle_i,
  output trig_res_t        trig_o
);

  localparam trig_t CORDIC_GAIN = TRIG_W'(652032874);
  localparam logic signed [TRIG_W:0] ONE_Q = $signed((TRIG_W+1)'(1) << ONE_SHIFT);
  localparam logic [ANG_W-1:0] ANG_QUARTER = ANG_W'(1) << (ANG_W-2);

  trig_t     x_q    [TRIG_ITERATIONS+1];
  trig_t     y_q    [TRIG_ITERATIONS+1];
  trig_t     z_q    [TRIG_ITERATIONS+1];
  logic      flip_q [TRIG_ITERATIONS+1];
  trig_res_t trig_q;

  logic [ANG_W-1:0] ang_sum;
  logic             flip;
  logic [ANG_W-1:0] ang_adj;
  trig_t            z0;
  trig_t            c_fin;
  trig_t            s_fin;

  // second and third quarter turn: rotate by half a turn, negate afterwards
  assign ang_sum = angle_i + ANG_QUARTER;
  assign flip    = ang_sum[ANG_W-1];
  assign ang_adj = angle_i ^ {flip, {(ANG_W-1){1'b0}}};
  assign z0      = TRIG_W'($signed({ang_adj, {(PHASE_W-ANG_W){1'b0}}}));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= z0;
      flip_q[0] <= flip;
    end
  end

  for (genvar i = 0; i < TRIG_ITERATIONS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][TRIG_W-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - atan_turn(i);
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + atan_turn(i);
        end
        flip_q[i+1] <= flip_q[i];
      end
    end
  end

  assign c_fin = flip_q[TRIG_ITERATIONS] ? -x_q[TRIG_ITERATIONS] : x_q[TRIG_ITERATIONS];
  assign s_fin = flip_q[TRIG_ITERATIONS] ? -y_q[TRIG_ITERATIONS] : y_q[TRIG_ITERATIONS];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_q.c   <= c_fin;
      trig_q.s   <= s_fin;
      trig_q.omc <= ONE_Q - (TRIG_W+1)'(c_fin);
    end
  end

  assign trig_o = trig_q;

endmodule

// File: sv/vaar_lane.sv
// one output component: the three rodrigues terms, rounding and saturation
module vaar_lane import vaar_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  vec_res_t                vec_i,
  input  trig_res_t               trig_i,
  output logic signed [VEC_W-1:0] out_o
);

  localparam int RW = TERM_W - GUARD;
  localparam logic signed [TERM_W-1:0] HALF_LSB = $signed(TERM_W'(1) << (GUARD-1));

  // round to nearest, ties away from zero, on a magnitude
  function automatic logic [MAG_W-1:0] rnd_shr(input logic [PROD_W-1:0] p,
                                               input int unsigned sh);
    logic [PROD_W-1:0] t;
    t = (p + (PROD_W'(1) << (sh - 1))) >> sh;
    return t[MAG_W-1:0];
  endfunction

  function automatic logic signed [TERM_W-1:0] with_sign(input logic [MAG_W-1:0] mag,
                                                         input logic neg);
    logic signed [TERM_W-1:0] m;
    m = $signed(TERM_W'(mag));
    return neg ? -m : m;
  endfunction

  // magnitudes of the operands
  logic [VEC_W-1:0]  vmag;
  logic [AXIS_W-1:0] kmag;
  logic [MAG_W-1:0]  dmag;
  logic [MAG_W-1:0]  crmag;
  logic [31:0]       cmag;
  logic [31:0]       smag;
  trig_t             cneg;
  trig_t             sneg;

  assign vmag  = vec_i.v[VEC_W-1]    ? VEC_W'(-vec_i.v)  : VEC_W'(vec_i.v);
  assign kmag  = vec_i.k[AXIS_W-1]   ? AXIS_W'(-vec_i.k) : AXIS_W'(vec_i.k);
  assign dmag  = vec_i.dotw[MAG_W-1] ? MAG_W'(-vec_i.dotw) : MAG_W'(vec_i.dotw);
  assign crmag = vec_i.cr[MAG_W-1]   ? MAG_W'(-vec_i.cr)   : MAG_W'(vec_i.cr);
  assign cneg  = -trig_i.c;
  assign sneg  = -trig_i.s;
  assign cmag  = trig_i.c[TRIG_W-1] ? cneg[31:0] : trig_i.c[31:0];
  assign smag  = trig_i.s[TRIG_W-1] ? sneg[31:0] : trig_i.s[31:0];

  // stage 1: partial products
  logic [63:0]                 p1_q;
  logic [AXIS_W+HALF_W-1:0]    kd_lo_q, kd_hi_q;
  logic [HALF_W+31:0]          cs_lo_q, cs_hi_q;
  logic                        n1_q, nu_q, n3_q;
  logic signed [TRIG_W:0]      omc1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q    <= 64'(vmag) * 64'(cmag);
      kd_lo_q <= (AXIS_W+HALF_W)'(kmag) * (AXIS_W+HALF_W)'(dmag[HALF_W-1:0]);
      kd_hi_q <= (AXIS_W+HALF_W)'(kmag) * (AXIS_W+HALF_W)'(dmag[MAG_W-1:HALF_W]);
      cs_lo_q <= (HALF_W+32)'(crmag[HALF_W-1:0]) * (HALF_W+32)'(smag);
      cs_hi_q <= (HALF_W+32)'(crmag[MAG_W-1:HALF_W]) * (HALF_W+32)'(smag);
      n1_q    <= vec_i.v[VEC_W-1] ^ trig_i.c[TRIG_W-1];
      nu_q    <= vec_i.k[AXIS_W-1] ^ vec_i.dotw[MAG_W-1];
      n3_q    <= vec_i.cr[MAG_W-1] ^ trig_i.s[TRIG_W-1];
      omc1_q  <= trig_i.omc;
    end
  end

  // stage 2: recombine and round the first products
  logic signed [TERM_W-1:0] t1_2_q, t3_2_q;
  logic [MAG_W-1:0]         umag_q;
  logic                     nu2_q;
  logic signed [TRIG_W:0]   omc2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_2_q <= with_sign(rnd_shr(PROD_W'(p1_q), ONE_SHIFT - GUARD), n1_q);
      umag_q <= rnd_shr((PROD_W'(kd_hi_q) << HALF_W) + PROD_W'(kd_lo_q), AXIS_FRAC);
      t3_2_q <= with_sign(rnd_shr((PROD_W'(cs_hi_q) << HALF_W) + PROD_W'(cs_lo_q),
                                  ONE_SHIFT), n3_q);
      nu2_q  <= nu_q;
      omc2_q <= omc1_q;
    end
  end

  // stage 3: u times one minus cos, split in two
  logic [TRIG_W:0]          omneg;
  logic [31:0]              omag;
  logic [HALF_W+31:0]       uo_lo_q, uo_hi_q;
  logic                     n2_q;
  logic signed [TERM_W-1:0] t1_3_q, t3_3_q;

  assign omneg = -omc2_q;
  assign omag  = omc2_q[TRIG_W] ? omneg[31:0] : omc2_q[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      uo_lo_q <= (HALF_W+32)'(umag_q[HALF_W-1:0]) * (HALF_W+32)'(omag);
      uo_hi_q <= (HALF_W+32)'(umag_q[MAG_W-1:HALF_W]) * (HALF_W+32)'(omag);
      n2_q    <= nu2_q ^ omc2_q[TRIG_W];
      t1_3_q  <= t1_2_q;
      t3_3_q  <= t3_2_q;
    end
  end

  // stage 4: axial term
  logic signed [TERM_W-1:0] t1_4_q, t2_4_q, t3_4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t2_4_q <= with_sign(rnd_shr((PROD_W'(uo_hi_q) << HALF_W) + PROD_W'(uo_lo_q),
                                  ONE_SHIFT), n2_q);
      t1_4_q <= t1_3_q;
      t3_4_q <= t3_3_q;
    end
  end

  // stage 5: sum, round to q16.16, saturate
  logic signed [TERM_W-1:0] sum;
  logic signed [TERM_W-1:0] sum_sh;
  logic signed [RW-1:0]     r;
  logic                     ovf;
  logic signed [VEC_W-1:0]  sat;
  logic signed [VEC_W-1:0]  out_q;

  assign sum    = t1_4_q + t2_4_q - t3_4_q + HALF_LSB;
  assign sum_sh = sum >>> GUARD;
  assign r      = sum_sh[RW-1:0];
  assign ovf    = (r[RW-1:VEC_W-1] != '0) && (r[RW-1:VEC_W-1] != '1);
  assign sat    = ovf ? (r[RW-1] ? {1'b1, {(VEC_W-1){1'b0}}} : {1'b0, {(VEC_W-1){1'b1}}})
                      : r[VEC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q <= sat;
    end
  end

  assign out_o = out_q;

endmodule

// File: sv/vector_axis_angle_rotation_top.sv
// top level of the axis-angle (rodrigues) vector rotator
//
// rotates a q16.16 vector about a q2.14 unit axis by a binary angle (65536 per
// turn): out = v*cos + k*(k.v)*(1-cos) - (v x k)*sin, each component rounded
// and saturated to q16.16. the axis is used as given, no normalization. the
// block is one pipeline with a single stall enable: it takes one beat per
// clock while the pipeline is not held. a beat passes the product registers,
// the dot and cross registers, TRIG_ITERATIONS delay stages alongside the
// cordic, then the registers of the per-component lanes. the cordic sets that
// depth: one stage per iteration plus entry and exit registers. s_axis_tready
// stays high unless the final result register holds a beat that the sink has
// not taken; then the whole pipeline holds.
module vector_axis_angle_rotation_top import vaar_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_z
  output logic [95:0]  m_axis_tdata
);

  localparam int LAT = TRIG_ITERATIONS + 7;

  logic en;
  logic [LAT-1:0] vld_q;

  // one global enable: advance unless the result register is stuck
  assign en            = !vld_q[LAT-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  // beat unpacking
  logic signed [VEC_W-1:0]  v_in [3];
  logic signed [AXIS_W-1:0] k_in [3];
  logic [ANG_W-1:0]         angle;

  assign v_in[0] = s_axis_tdata[31:0];
  assign v_in[1] = s_axis_tdata[63:32];
  assign v_in[2] = s_axis_tdata[95:64];
  assign k_in[0] = s_axis_tdata[111:96];
  assign k_in[1] = s_axis_tdata[127:112];
  assign k_in[2] = s_axis_tdata[143:128];
  assign angle   = s_axis_tdata[159:144];

  // stage a: axis times vector products, kv_q[i][j] = k[i] * v[j]
  logic signed [KV_W-1:0]   kv_q [3][3];
  logic signed [VEC_W-1:0]  va_q [3];
  logic signed [AXIS_W-1:0] ka_q [3];

  for (genvar i = 0; i < 3; i++) begin : g_prod
    for (genvar j = 0; j < 3; j++) begin : g_col
      always_ff @(posedge clk_i) begin
        if (en) begin
          kv_q[i][j] <= KV_W'(k_in[i]) * KV_W'(v_in[j]);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        va_q[i] <= v_in[i];
        ka_q[i] <= k_in[i];
      end
    end
  end

  // stage b: dot and cross on the guard grid, then delay to meet the cordic
  logic signed [MAG_W-1:0] dotw;
  logic signed [MAG_W-1:0] cr [3];
  vec_res_t                dly_q [TRIG_ITERATIONS+1][3];

  assign dotw  = (MAG_W'(kv_q[0][0]) + MAG_W'(kv_q[1][1]) + MAG_W'(kv_q[2][2])) <<< 2;
  assign cr[0] = (MAG_W'(kv_q[2][1]) - MAG_W'(kv_q[1][2])) <<< 2;
  assign cr[1] = (MAG_W'(kv_q[0][2]) - MAG_W'(kv_q[2][0])) <<< 2;
  assign cr[2] = (MAG_W'(kv_q[1][0]) - MAG_W'(kv_q[0][1])) <<< 2;

  for (genvar j = 0; j < 3; j++) begin : g_dly
    always_ff @(posedge clk_i) begin
      if (en) begin
        dly_q[0][j].v    <= va_q[j];
        dly_q[0][j].k    <= ka_q[j];
        dly_q[0][j].dotw <= dotw;
        dly_q[0][j].cr   <= cr[j];
      end
    end
    for (genvar d = 1; d <= TRIG_ITERATIONS; d++) begin : g_tap
      always_ff @(posedge clk_i) begin
        if (en) begin
          dly_q[d][j] <= dly_q[d-1][j];
        end
      end
    end
  end

  // shared trig unit
  trig_res_t trig;

  vaar_cordic #(
    .TRIG_ITERATIONS(TRIG_ITERATIONS)
  ) u_cordic (
    .clk_i  (clk_i),
    .en_i   (en),
    .angle_i(angle),
    .trig_o (trig)
  );

  // one lane per component
  logic signed [VEC_W-1:0] out_c [3];

  for (genvar j = 0; j < 3; j++) begin : g_lane
    vaar_lane u_lane (
      .clk_i (clk_i),
      .en_i  (en),
      .vec_i (dly_q[TRIG_ITERATIONS][j]),
      .trig_i(trig),
      .out_o (out_c[j])
    );
  end

  // merge lanes into the result beat
  assign m_axis_tdata = {out_c[2], out_c[1], out_c[0]};

endmodule

// File: bench/tb_vector_axis_angle_rotation_top.sv
// testbench of the axis-angle vector rotator: random stream stimulus, bit-exact prediction
module tb_vector_axis_angle_rotation_top;
  import vaar_pkg::*;

  localparam int LATENCY   = TRIG_ITERATIONS_DEF + 7;
  localparam int CYCLE_CAP = 400000;
  localparam logic signed [63:0] CAP = 64'sd1 <<< 60;

  typedef struct packed {
    logic [15:0] angle;
    logic signed [15:0] kz, ky, kx;
    logic signed [31:0] vz, vy, vx;
  } rot_in_t;

  typedef struct packed {
    logic signed [31:0] z, y, x;
  } rot_out_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [159:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;

  rot_in_t  pending_q[$];
  rot_out_t rotated_q[$];
  int       mismatches;
  int       cycles;
  bit       hold_sink;
  bit       hold_source;
  int       burst_left;
  int       gap_left;

  vector_axis_angle_rotation_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // round(a*b / 2^sh) ties away from zero, magnitude capped at 2^60
  function automatic logic signed [63:0] scale_round(logic signed [63:0] a,
                                                     logic signed [63:0] b, int sh);
    logic [127:0] ua, ub, p, m;
    logic         neg;
    neg = (a < 0) != (b < 0);
    ua  = (a < 0) ? 128'(-a) : 128'(a);
    ub  = (b < 0) ? 128'(-b) : 128'(b);
    p   = ua * ub;
    m   = (p + (128'd1 << (sh - 1))) >> sh;
    if (m > 128'(CAP)) m = 128'(CAP);
    return neg ? -$signed(64'(m)) : $signed(64'(m));
  endfunction

  // cordic sine and cosine in q2.30 with half-turn folding
  function automatic void sin_cos(input logic [15:0] ang, output logic signed [63:0] c,
                                  output logic signed [63:0] s);
    logic [31:0]        ph;
    logic               flip;
    logic signed [63:0] x, y, z, dx, dy;
    ph   = {ang, 16'h0};
    flip = ((ph + 32'h4000_0000) >> 31) != 0;
    if (flip) ph = ph - 32'h8000_0000;
    x = 64'sd652032874;
    y = 0;
    z = 64'($signed(ph));
    for (int i = 0; i < TRIG_ITERATIONS_DEF && i < ATAN_ENTRIES; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - 64'(atan_turn(i));
      end else begin
        x = x + dx; y = y - dy; z = z + 64'(atan_turn(i));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic rot_out_t rotate(rot_in_t it);
    logic signed [63:0] v[3], k[3], cr[3], c, s, omc, dotw, t1, t2, t3, r;
    logic signed [31:0] res[3];
    v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
    k[0] = it.kx; k[1] = it.ky; k[2] = it.kz;
    sin_cos(it.angle, c, s);
    omc   = (64'sd1 <<< ONE_SHIFT) - c;
    dotw  = (k[0] * v[0] + k[1] * v[1] + k[2] * v[2]) * 4;
    cr[0] = (v[1] * k[2] - v[2] * k[1]) * 4;
    cr[1] = (v[2] * k[0] - v[0] * k[2]) * 4;
    cr[2] = (v[0] * k[1] - v[1] * k[0]) * 4;
    for (int j = 0; j < 3; j++) begin
      t1 = scale_round(v[j], c, ONE_SHIFT - GUARD);
      t2 = scale_round(scale_round(k[j], dotw, AXIS_FRAC), omc, ONE_SHIFT);
      t3 = scale_round(cr[j], s, ONE_SHIFT);
      r  = (t1 + t2 - t3 + (64'sd1 <<< (GUARD - 1))) >>> GUARD;
      if (r > 64'sd2147483647) r = 64'sd2147483647;
      if (r < -64'sd2147483648) r = -64'sd2147483648;
      res[j] = r[31:0];
    end
    return '{z: res[2], y: res[1], x: res[0]};
  endfunction

  // random field values weighted toward extremes and small magnitudes
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'($signed($urandom_range(0, 2 * 65536 * 100)) - 65536 * 100);
      default: return $urandom;
    endcase
  endfunction

  function automatic rot_in_t random_item();
    rot_in_t it;
    int      a;
    it.vx = pick32(); it.vy = pick32(); it.vz = pick32();
    a = $urandom_range(0, 3);
    // mostly unit axes, some arbitrary ones
    if ($urandom_range(0, 3) != 0) begin
      it.kx = (a == 0) ? 16'sd16384 : 16'sd0;
      it.ky = (a == 1) ? 16'sd16384 : 16'sd0;
      it.kz = (a == 2) ? -16'sd16384 : 16'sd0;
      if (a == 3) begin
        it.kx = 16'sd9459; it.ky = -16'sd9459; it.kz = 16'sd9459;
      end
    end else begin
      it.kx = 16'($urandom); it.ky = 16'($urandom); it.kz = 16'($urandom);
    end
    it.angle = 16'($urandom);
    return it;
  endfunction

  task automatic push_item(rot_in_t it);
    pending_q.push_back(it);
  endtask

  // accepted input beats, taken at the rising edge where the handshake happens
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      rotated_q.push_back(rotate(pending_q.pop_front()));
    end
  end

  // driver: bursts and gaps, falling-edge updates
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
      end else if (burst_left == 0) begin
        burst_left = $urandom_range(1, 30);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
      end else begin
        burst_left = burst_left - 1;
      end
      if (pending_q.size() > 0 && gap_left == 0 && !hold_source) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pending_q[0];
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // sink stall pattern, overridden during the long hold-off
  always @(negedge clk_i) begin
    if (hold_sink) m_axis_tready <= 1'b0;
    else if (cycles % 200 < 60) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  // monitor: compare every result beat with the oldest prediction
  always @(posedge clk_i) begin
    rot_out_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (rotated_q.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = rotated_q.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h z=%h, got x=%h y=%h z=%h",
                     want.x, want.y, want.z, got.x, got.y, got.z);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles = cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("vector_axis_angle_rotation_top test failed");
      $finish;
    end
  end

  initial begin
    rot_in_t     it;
    logic [15:0] dir_ang [8];
    mismatches    = 0;
    cycles        = 0;
    burst_left    = 0;
    gap_left      = 0;
    hold_sink     = 1'b0;
    hold_source   = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    dir_ang       = '{16'h0000, 16'h4000, 16'h8000, 16'hc000, 16'h3fff, 16'hbfff,
                      16'hffff, 16'h2000};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extreme fields, the four quadrant angles and fold boundaries,
    // a non-unit axis, saturating overflow
    for (int n = 0; n < 8; n++) begin
      it = '{angle: dir_ang[n],
             kz: 16'sd0, ky: 16'sd0, kx: 16'sd16384,
             vz: 32'sd65536, vy: 32'sd131072, vx: -32'sd196608};
      push_item(it);
    end
    push_item('{angle: 16'h4000, kz: 16'sd16384, ky: 16'sd0, kx: 16'sd0,
                vz: 32'sh7fff_ffff, vy: 32'sh7fff_ffff, vx: 32'sh7fff_ffff});
    push_item('{angle: 16'h6000, kz: 16'sh7fff, ky: 16'sh7fff, kx: 16'sh7fff,
                vz: 32'sh7fff_ffff, vy: 32'sh8000_0000, vx: 32'sh7fff_ffff});
    push_item('{angle: 16'h8000, kz: 16'sh8000, ky: 16'sh8000, kx: 16'sh8000,
                vz: 32'sh8000_0000, vy: 32'sh8000_0000, vx: 32'sh8000_0000});
    push_item('{angle: 16'h1234, kz: 16'sd0, ky: 16'sd0, kx: 16'sd0,
                vz: 32'sd0, vy: 32'sd0, vx: 32'sd0});
    push_item('{angle: 16'hffff, kz: 16'shffff, ky: 16'shffff, kx: 16'shffff,
                vz: 32'shffff_ffff, vy: 32'shffff_ffff, vx: 32'shffff_ffff});
    push_item('{angle: 16'h5555, kz: 16'sh5555, ky: 16'shaaaa, kx: 16'sh5555,
                vz: 32'sh5555_5555, vy: 32'shaaaa_aaaa, vx: 32'sh5555_5555});
    push_item('{angle: 16'haaaa, kz: 16'shaaaa, ky: 16'sh5555, kx: 16'shaaaa,
                vz: 32'shaaaa_aaaa, vy: 32'sh5555_5555, vx: 32'shaaaa_aaaa});
    while (pending_q.size() > 0 || rotated_q.size() > 0) @(posedge clk_i);

    // long sink hold-off while the source keeps offering beats
    for (int n = 0; n < 100; n++) push_item(random_item());
    hold_sink = 1'b1;
    repeat (3 * LATENCY) @(posedge clk_i);
    hold_sink = 1'b0;

    // source pause until the pipeline has drained
    while (pending_q.size() > 0) @(posedge clk_i);
    hold_source = 1'b1;
    while (rotated_q.size() > 0) @(posedge clk_i);
    hold_source = 1'b0;

    for (int n = 0; n < 590; n++) push_item(random_item());
    while (pending_q.size() > 0) @(posedge clk_i);
    while (rotated_q.size() > 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);

    if (mismatches == 0 && rotated_q.size() == 0) begin
      $display("vector_axis_angle_rotation_top test passed");
    end else begin
      $display("vector_axis_angle_rotation_top test failed");
    end
    $finish;
  end

endmodule
